// ===== hdl/hbd_pkg.sv =====
// Shared types and constants of the Huffman block decoder.
`default_nettype none
package hbd_pkg;

  typedef enum logic [1:0] {
    KIND_SYMBOL = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE        = 2'd0,
    ERR_OVERFLOW    = 2'd1,
    ERR_SINGLE_LEAF = 2'd2
  } err_e;

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_HDR2,
    PH_TREE,
    PH_DATA,
    PH_HALT
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BYTE,
    ST_TREE,
    ST_DISSUE,
    ST_DCHECK,
    ST_FLUSH
  } state_e;

  localparam int unsigned CountW = 22;
  localparam int unsigned OutDataW = 40;

  typedef struct packed {
    kind_e              kind;
    logic [7:0]         symbol;
    logic               block_done;
    logic               final_block;
    logic               rle_used;
    logic [CountW-1:0]  block_symbols;
    err_e               error_code;
  } result_t;

endpackage
`default_nettype wire

// ===== hdl/huffman_block_decoder.sv =====
// Huffman block decoder: header parse, preorder tree build and tree walk.
//
// Each input word is one compressed byte, bits taken MSB first. A block opens
// with a 3-byte little-endian header (one header result), then a preorder
// tree padded to a byte, then data bits walking the tree, one symbol result
// per leaf. Every byte is accepted in ST_IDLE, dispatched on the current phase
// in ST_BYTE and closed in ST_FLUSH, which marks the last result of that byte
// with tlast. A tree byte handles its bits in ST_TREE, each bit doing at most
// one node-store access and at most one stack access. A data byte handles each
// bit in two steps: ST_DISSUE reads the next node from the node store and
// ST_DCHECK inspects the registered read data. A byte stops early where the
// tree or the block completes. Results are held while the output side stalls,
// and the byte in progress waits with them. An overflow of the node store or
// stack, or a tree with a single leaf, gives one error result and then all
// further bytes are dropped until reset. Node store and stack need no clearing
// after reset.
`default_nettype none
module huffman_block_decoder #(
  parameter int unsigned MAX_NODES   = 512,
  parameter int unsigned STACK_DEPTH = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // stream_byte[7:0]
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // symbol[7:0], block_done[8], final_block[9], rle_used[10],
  // block_symbols[32:11], error_code[34:33], zero fill[39:35]
  output logic [hbd_pkg::OutDataW-1:0] m_axis_tdata_o,
  output logic [1:0]       m_axis_tuser_o,   // kind[1:0]
  output logic             m_axis_tlast_o    // last_in_run
);
  import hbd_pkg::*;

  localparam int unsigned IdxW  = $clog2(MAX_NODES);
  localparam int unsigned ValW  = (IdxW > 8) ? IdxW : 8;
  localparam int unsigned NodeW = ValW + 1;
  localparam int unsigned CntW  = $clog2(MAX_NODES + 1);
  localparam int unsigned SpW   = $clog2(STACK_DEPTH);
  localparam int unsigned TopW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned NxtW  = IdxW + 1;

  state_e            state_q, state_d;
  phase_e            phase_q, phase_d;
  logic [7:0]        byte_q, byte_d;
  logic [2:0]        bit_idx_q, bit_idx_d;
  logic [23:0]       hdr_q, hdr_d;
  logic [CountW-1:0] left_q, left_d;
  logic              final_q, final_d;
  logic              rle_q, rle_d;
  logic [TopW-1:0]   top_q, top_d;
  logic [CntW-1:0]   ncount_q, ncount_d;
  logic [IdxW-1:0]   walk_q, walk_d;
  logic [IdxW-1:0]   walkval_q, walkval_d;
  logic [IdxW-1:0]   next_q, next_d;
  logic [IdxW-1:0]   root_right_q, root_right_d;
  logic [7:0]        leaf_bits_q, leaf_bits_d;
  logic [3:0]        leaf_cnt_q, leaf_cnt_d;
  logic              attach_q, attach_d;
  logic              pend_valid_q, pend_valid_d;
  result_t           pend_q, pend_d;
  logic              out_valid_q, out_valid_d;
  result_t           out_q, out_d;
  logic              out_last_q, out_last_d;

  logic              node_we, node_re;
  logic [IdxW-1:0]   node_waddr, node_raddr;
  logic [NodeW-1:0]  node_wdata, node_rdata;
  logic              stk_we, stk_re;
  logic [SpW-1:0]    stk_waddr, stk_raddr;
  logic [IdxW-1:0]   stk_wdata, stk_rdata;

  logic              emit;
  result_t           emit_res;
  logic              can_emit, slot_free, cur_bit;
  logic [7:0]        leaf_new;
  logic [CntW-1:0]   ncount_dec;
  logic [TopW-1:0]   top_dec;
  logic [IdxW-1:0]   new_idx;
  logic [NxtW-1:0]   next_wide;
  logic [CountW-1:0] left_dec;

  hbd_ram #(.WIDTH(NodeW), .DEPTH(MAX_NODES)) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .waddr_i (node_waddr),
    .wdata_i (node_wdata),
    .re_i    (node_re),
    .raddr_i (node_raddr),
    .rdata_o (node_rdata)
  );

  hbd_ram #(.WIDTH(IdxW), .DEPTH(STACK_DEPTH)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  function automatic result_t mk_res(kind_e k, logic [7:0] sym, logic done,
                                     logic fin, logic rle, logic [CountW-1:0] cnt,
                                     err_e err);
    result_t r;
    r.kind          = k;
    r.symbol        = sym;
    r.block_done    = done;
    r.final_block   = fin;
    r.rle_used      = rle;
    r.block_symbols = cnt;
    r.error_code    = err;
    return r;
  endfunction

  assign slot_free  = !out_valid_q || m_axis_tready_i;
  assign can_emit   = !pend_valid_q || slot_free;
  assign cur_bit    = byte_q[bit_idx_q];
  assign leaf_new   = {leaf_bits_q[6:0], cur_bit};
  assign ncount_dec = ncount_q - 1'b1;
  assign top_dec    = top_q - 1'b1;
  assign new_idx    = ncount_q[IdxW-1:0];
  assign left_dec   = left_q - 1'b1;

  always_comb begin
    next_wide = cur_bit ? {1'b0, walkval_q} : ({1'b0, walk_q} + 1'b1);
    if (next_wide >= NxtW'(MAX_NODES)) begin
      next_wide = '0;
    end
  end

  always_comb begin
    state_d      = state_q;
    phase_d      = phase_q;
    byte_d       = byte_q;
    bit_idx_d    = bit_idx_q;
    hdr_d        = hdr_q;
    left_d       = left_q;
    final_d      = final_q;
    rle_d        = rle_q;
    top_d        = top_q;
    ncount_d     = ncount_q;
    walk_d       = walk_q;
    walkval_d    = walkval_q;
    next_d       = next_q;
    root_right_d = root_right_q;
    leaf_bits_d  = leaf_bits_q;
    leaf_cnt_d   = leaf_cnt_q;
    attach_d     = attach_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_d        = out_q;
    out_last_d   = out_last_q;
    node_we      = 1'b0;
    node_re      = 1'b0;
    node_waddr   = '0;
    node_raddr   = '0;
    node_wdata   = '0;
    stk_we       = 1'b0;
    stk_re       = 1'b0;
    stk_waddr    = '0;
    stk_raddr    = '0;
    stk_wdata    = '0;
    emit         = 1'b0;
    emit_res     = mk_res(KIND_ERROR, 8'd0, 1'b0, final_q, rle_q, hdr_q[CountW-1:0],
                          ERR_NONE);
    s_axis_tready_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          byte_d    = s_axis_tdata_i;
          bit_idx_d = 3'd7;
          state_d   = ST_BYTE;
        end
      end

      ST_BYTE: begin
        if (can_emit) begin
          unique case (phase_q)
            PH_HDR0: begin
              hdr_d   = {16'd0, byte_q};
              phase_d = PH_HDR1;
              state_d = ST_FLUSH;
            end
            PH_HDR1: begin
              hdr_d[15:8] = byte_q;
              phase_d     = PH_HDR2;
              state_d     = ST_FLUSH;
            end
            PH_HDR2: begin
              hdr_d[23:16] = byte_q;
              final_d      = byte_q[7];
              rle_d        = byte_q[6];
              left_d       = {byte_q[5:0], hdr_q[15:0]};
              ncount_d     = '0;
              top_d        = '0;
              attach_d     = 1'b0;
              walk_d       = '0;
              leaf_bits_d  = '0;
              leaf_cnt_d   = '0;
              emit         = 1'b1;
              emit_res     = mk_res(KIND_HEADER, 8'd0, 1'b0, byte_q[7], byte_q[6],
                                    {byte_q[5:0], hdr_q[15:0]}, ERR_NONE);
              phase_d      = PH_TREE;
              state_d      = ST_FLUSH;
            end
            PH_TREE: state_d = ST_TREE;
            PH_DATA: state_d = ST_DISSUE;
            default: state_d = ST_FLUSH;
          endcase
        end
      end

      ST_TREE: begin
        if (can_emit) begin
          state_d = ST_TREE;
          if (bit_idx_q == 3'd0) begin
            state_d = ST_FLUSH;
          end else begin
            bit_idx_d = bit_idx_q - 3'd1;
          end
          if (leaf_cnt_q != 4'd0) begin
            leaf_bits_d = leaf_new;
            leaf_cnt_d  = leaf_cnt_q - 4'd1;
            if (leaf_cnt_q == 4'd1) begin
              node_we    = 1'b1;
              node_waddr = ncount_dec[IdxW-1:0];
              node_wdata = {1'b1, ValW'(leaf_new)};
              if (top_q == '0) begin
                // tree complete: rest of byte is padding
                state_d = ST_FLUSH;
                if (ncount_q == CntW'(1)) begin
                  emit     = 1'b1;
                  emit_res = mk_res(KIND_ERROR, 8'd0, 1'b0, final_q, rle_q,
                                    hdr_q[CountW-1:0], ERR_SINGLE_LEAF);
                  phase_d  = PH_HALT;
                end else if (left_q != '0) begin
                  phase_d   = PH_DATA;
                  walkval_d = root_right_q;
                end else begin
                  phase_d = PH_HDR0;
                end
              end else begin
                top_d     = top_dec;
                stk_re    = 1'b1;
                stk_raddr = top_dec[SpW-1:0];
                attach_d  = 1'b1;
              end
            end
          end else if (ncount_q >= CntW'(MAX_NODES)) begin
            emit     = 1'b1;
            emit_res = mk_res(KIND_ERROR, 8'd0, 1'b0, final_q, rle_q,
                              hdr_q[CountW-1:0], ERR_OVERFLOW);
            phase_d  = PH_HALT;
            state_d  = ST_FLUSH;
          end else begin
            ncount_d = ncount_q + 1'b1;
            if (attach_q) begin
              node_we    = 1'b1;
              node_waddr = stk_rdata;
              node_wdata = {1'b0, ValW'(new_idx)};
              attach_d   = 1'b0;
              if (stk_rdata == '0) begin
                root_right_d = new_idx;
              end
            end
            if (cur_bit) begin
              leaf_cnt_d  = 4'd8;
              leaf_bits_d = '0;
            end else if (top_q >= TopW'(STACK_DEPTH)) begin
              emit     = 1'b1;
              emit_res = mk_res(KIND_ERROR, 8'd0, 1'b0, final_q, rle_q,
                                hdr_q[CountW-1:0], ERR_OVERFLOW);
              phase_d  = PH_HALT;
              state_d  = ST_FLUSH;
            end else begin
              stk_we    = 1'b1;
              stk_waddr = top_q[SpW-1:0];
              stk_wdata = new_idx;
              top_d     = top_q + 1'b1;
            end
          end
        end
      end

      ST_DISSUE: begin
        node_re    = 1'b1;
        node_raddr = next_wide[IdxW-1:0];
        next_d     = next_wide[IdxW-1:0];
        state_d    = ST_DCHECK;
      end

      ST_DCHECK: begin
        if (can_emit) begin
          if (bit_idx_q == 3'd0) begin
            state_d = ST_FLUSH;
          end else begin
            bit_idx_d = bit_idx_q - 3'd1;
            state_d   = ST_DISSUE;
          end
          if (node_rdata[NodeW-1]) begin
            left_d    = left_dec;
            emit      = 1'b1;
            emit_res  = mk_res(KIND_SYMBOL, node_rdata[7:0], left_dec == '0,
                               final_q, rle_q, hdr_q[CountW-1:0], ERR_NONE);
            walk_d    = '0;
            walkval_d = root_right_q;
            if (left_dec == '0) begin
              phase_d = PH_HDR0;
              state_d = ST_FLUSH;
            end
          end else begin
            walk_d    = next_q;
            walkval_d = node_rdata[IdxW-1:0];
          end
        end
      end

      ST_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = ST_IDLE;
        end else if (slot_free) begin
          out_valid_d  = 1'b1;
          out_d        = pend_q;
          out_last_d   = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    // hold one result back so the byte's last one can carry tlast
    if (emit) begin
      if (pend_valid_q) begin
        out_valid_d = 1'b1;
        out_d       = pend_q;
        out_last_d  = 1'b0;
      end
      pend_valid_d = 1'b1;
      pend_d       = emit_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      phase_q      <= PH_HDR0;
      hdr_q        <= '0;
      left_q       <= '0;
      final_q      <= 1'b0;
      rle_q        <= 1'b0;
      top_q        <= '0;
      ncount_q     <= '0;
      walk_q       <= '0;
      leaf_bits_q  <= '0;
      leaf_cnt_q   <= '0;
      attach_q     <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      root_right_q <= '0;
      walkval_q    <= '0;
    end else begin
      state_q      <= state_d;
      phase_q      <= phase_d;
      hdr_q        <= hdr_d;
      left_q       <= left_d;
      final_q      <= final_d;
      rle_q        <= rle_d;
      top_q        <= top_d;
      ncount_q     <= ncount_d;
      walk_q       <= walk_d;
      leaf_bits_q  <= leaf_bits_d;
      leaf_cnt_q   <= leaf_cnt_d;
      attach_q     <= attach_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      root_right_q <= root_right_d;
      walkval_q    <= walkval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q     <= byte_d;
    bit_idx_q  <= bit_idx_d;
    next_q     <= next_d;
    pend_q     <= pend_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'd0, out_q.error_code, out_q.block_symbols, out_q.rle_used,
                            out_q.final_block, out_q.block_done, out_q.symbol};
  assign m_axis_tuser_o  = out_q.kind;
  assign m_axis_tlast_o  = out_last_q;

  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    top_q <= TopW'(STACK_DEPTH))
    else $error("stack pointer beyond depth");

  a_node_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ncount_q <= CntW'(MAX_NODES))
    else $error("node count beyond store size");

  a_accept_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |-> !pend_valid_q)
    else $error("byte taken with a result still held back");

endmodule
`default_nettype wire

// ===== hdl/hbd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module hbd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== tb/huffman_block_decoder_tb.sv =====
// Self-checking testbench for the Huffman block decoder, driven by directed and random stream traffic.
`default_nettype none
module huffman_block_decoder_tb;
  import hbd_pkg::*;

  localparam int NodeMax   = 512;
  localparam int StackMax  = 256;
  localparam int IdleLimit = 5000;

  typedef struct {
    logic [7:0] data;
    int         kind_typed; // -1 when only the decoder model applies
  } row_t;

  typedef struct {
    kind_e             kind;
    logic [7:0]        symbol;
    logic              block_done;
    logic              final_block;
    logic              rle_used;
    logic [CountW-1:0] block_symbols;
    err_e              error_code;
    logic              last;
  } decoded_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [7:0]          s_axis_tdata_i;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic [1:0]          m_axis_tuser_o;
  logic                m_axis_tlast_o;

  huffman_block_decoder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // Decoder model state
  phase_e      ph;
  logic [23:0] hdr_word;
  logic [21:0] syms_left;
  bit          leaf_flag [NodeMax];
  logic [8:0]  node_mem [NodeMax];
  logic [8:0]  pend_mem [StackMax];
  int          pend_top;
  int          nodes_used;
  logic [8:0]  walk_at;
  logic [7:0]  sym_bits;
  int          sym_bits_left;
  bit          attach_ok;
  logic [8:0]  attach_to;

  row_t        byte_q[$];
  decoded_t    decoded_q[$];
  bit          tree_bits[$];
  bit          code_bits[8][$];
  int          errors;
  int          typed_bad;
  int          sent;
  int          headers_seen;
  int          symbols_seen;
  int          errors_seen;
  int          idle_cycles;
  bit          feed_done;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic void emit(inout decoded_t run[$], input kind_e k, input logic [7:0] s,
                               input logic d, input err_e e);
    decoded_t r;
    r.kind = k;
    r.symbol = s;
    r.block_done = d;
    r.final_block = hdr_word[23];
    r.rle_used = hdr_word[22];
    r.block_symbols = hdr_word[21:0];
    r.error_code = e;
    r.last = 1'b0;
    run.push_back(r);
  endfunction

  function automatic void model_reset();
    ph = PH_HDR0;
    hdr_word = '0;
    syms_left = '0;
    pend_top = 0;
    nodes_used = 0;
    walk_at = '0;
    sym_bits = '0;
    sym_bits_left = 0;
    attach_ok = 1'b0;
    attach_to = '0;
    for (int i = 0; i < NodeMax; i++) begin
      leaf_flag[i] = 1'b0;
      node_mem[i] = '0;
    end
  endfunction

  // Decode one byte and queue the results it yields.
  function automatic int decode_byte(logic [7:0] b);
    decoded_t run[$];
    int nxt;
    logic bt;
    case (ph)
      PH_HDR0: begin
        hdr_word = {16'd0, b};
        ph = PH_HDR1;
      end
      PH_HDR1: begin
        hdr_word[15:8] = b;
        ph = PH_HDR2;
      end
      PH_HDR2: begin
        hdr_word[23:16] = b;
        syms_left = hdr_word[21:0];
        nodes_used = 0;
        pend_top = 0;
        attach_ok = 1'b0;
        walk_at = '0;
        sym_bits = '0;
        sym_bits_left = 0;
        emit(run, KIND_HEADER, 8'd0, 1'b0, ERR_NONE);
        ph = PH_TREE;
      end
      PH_TREE, PH_DATA: begin
        for (int i = 7; i >= 0; i--) begin
          bt = b[i];
          if (ph == PH_TREE) begin
            if (sym_bits_left > 0) begin
              sym_bits = {sym_bits[6:0], bt};
              sym_bits_left--;
              if (sym_bits_left == 0) begin
                node_mem[nodes_used-1] = {1'b0, sym_bits};
                if (pend_top == 0) begin
                  if (nodes_used == 1) begin
                    emit(run, KIND_ERROR, 8'd0, 1'b0, ERR_SINGLE_LEAF);
                    ph = PH_HALT;
                  end else begin
                    ph = (syms_left != 0) ? PH_DATA : PH_HDR0;
                  end
                  break;
                end
                pend_top--;
                attach_to = pend_mem[pend_top];
                attach_ok = 1'b1;
              end
            end else begin
              if (nodes_used >= NodeMax) begin
                emit(run, KIND_ERROR, 8'd0, 1'b0, ERR_OVERFLOW);
                ph = PH_HALT;
                break;
              end
              if (attach_ok) begin
                node_mem[attach_to] = nodes_used[8:0];
                attach_ok = 1'b0;
              end
              leaf_flag[nodes_used] = bt;
              if (bt) begin
                sym_bits_left = 8;
                sym_bits = '0;
              end else begin
                node_mem[nodes_used] = '0;
              end
              nodes_used++;
              if (!bt) begin
                if (pend_top >= StackMax) begin
                  emit(run, KIND_ERROR, 8'd0, 1'b0, ERR_OVERFLOW);
                  ph = PH_HALT;
                  break;
                end
                pend_mem[pend_top] = nodes_used[8:0] - 9'd1;
                pend_top++;
              end
            end
          end else begin
            nxt = bt ? int'(node_mem[walk_at]) : int'(walk_at) + 1;
            if (nxt >= NodeMax) nxt = 0;
            if (leaf_flag[nxt]) begin
              syms_left = syms_left - 22'd1;
              emit(run, KIND_SYMBOL, node_mem[nxt][7:0], syms_left == 0, ERR_NONE);
              walk_at = '0;
              if (syms_left == 0) begin
                ph = PH_HDR0;
                break;
              end
            end else begin
              walk_at = nxt[8:0];
            end
          end
        end
      end
      default: ;
    endcase
    if (run.size() > 0) run[$].last = 1'b1;
    foreach (run[i]) decoded_q.push_back(run[i]);
    return (run.size() > 0) ? int'(run[0].kind) : -1;
  endfunction

  function automatic void add_row(logic [7:0] d, int k = -1);
    row_t r;
    r.data = d;
    r.kind_typed = k;
    byte_q.push_back(r);
  endfunction

  function automatic void flush_bits(inout bit q[$]);
    logic [7:0] v;
    while (q.size() % 8 != 0) q.push_back($urandom_range(0, 1));
    while (q.size() > 0) begin
      for (int i = 7; i >= 0; i--) v[i] = q.pop_front();
      add_row(v);
    end
  endfunction

  // Preorder tree with the given leaf count; leaf codes land in code_bits.
  function automatic void grow_tree(int leaves, bit path[$], inout int leaf_idx);
    int split;
    logic [7:0] s;
    bit lp[$];
    bit rp[$];
    if (leaves == 1) begin
      s = $urandom_range(0, 255);
      tree_bits.push_back(1'b1);
      for (int i = 7; i >= 0; i--) tree_bits.push_back(s[i]);
      code_bits[leaf_idx] = path;
      leaf_idx++;
    end else begin
      tree_bits.push_back(1'b0);
      split = $urandom_range(1, leaves - 1);
      lp = path;
      lp.push_back(1'b0);
      rp = path;
      rp.push_back(1'b1);
      grow_tree(split, lp, leaf_idx);
      grow_tree(leaves - split, rp, leaf_idx);
    end
  endfunction

  function automatic void random_block();
    int count;
    int leaves;
    int li;
    int pick;
    bit root[$];
    bit dbits[$];
    logic [23:0] h;
    count = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 24);
    leaves = $urandom_range(2, 8);
    h = {$urandom_range(0, 1) == 1, $urandom_range(0, 1) == 1, 22'(count)};
    add_row(h[7:0]);
    add_row(h[15:8]);
    add_row(h[23:16], KIND_HEADER);
    tree_bits.delete();
    li = 0;
    grow_tree(leaves, root, li);
    flush_bits(tree_bits);
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, leaves - 1);
      for (int i = 0; i < code_bits[pick].size(); i++) dbits.push_back(code_bits[pick][i]);
    end
    flush_bits(dbits);
  endfunction

  task automatic build_stimulus();
    // count 3, final and rle set; tree {0x00, 0xFF}; data 0,1,1
    add_row(8'h03); add_row(8'h00); add_row(8'hC0, KIND_HEADER);
    add_row(8'h40); add_row(8'h3F); add_row(8'hE0);
    add_row(8'h60, KIND_SYMBOL);
    // zero symbol count: tree only, no data
    add_row(8'h00); add_row(8'h00); add_row(8'h00, KIND_HEADER);
    add_row(8'h40); add_row(8'h3F); add_row(8'hE0, -1);
    // count 8: one byte gives eight symbols
    add_row(8'h08); add_row(8'h00); add_row(8'h00, KIND_HEADER);
    add_row(8'h40); add_row(8'h3F); add_row(8'hE0);
    add_row(8'h55, KIND_SYMBOL);
    // final block of two, then a new header after it
    add_row(8'h02); add_row(8'h00); add_row(8'h80, KIND_HEADER);
    add_row(8'h40); add_row(8'h3F); add_row(8'hE0);
    add_row(8'h80, KIND_SYMBOL);
    while (byte_q.size() < 440) random_block();
    // end on a sticky error, then bytes that must be dropped
    add_row(8'h05); add_row(8'h00); add_row(8'h00, KIND_HEADER);
    if ($urandom_range(0, 1) == 1) begin
      add_row(8'hAB); add_row(8'hC0, KIND_ERROR); // single leaf
    end else begin
      for (int i = 0; i < 32; i++) add_row(8'h00);
      add_row(8'h00, KIND_ERROR);                 // stack full
    end
    for (int i = 0; i < 6; i++) add_row($urandom_range(0, 255), -1);
  endtask

  // Sender
  initial begin
    int gap;
    int got;
    row_t r;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    feed_done = 1'b0;
    rst_ni = 1'b0;
    model_reset();
    build_stimulus();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    while (byte_q.size() > 0) begin
      r = byte_q.pop_front();
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
          : ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
      if (gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      s_axis_tvalid_i <= 1'b1;
      s_axis_tdata_i <= r.data;
      do @(posedge clk_i); while (!s_axis_tready_o);
      got = decode_byte(r.data);
      if (r.kind_typed != -1 && got != r.kind_typed) begin
        $display("%0t: byte %h expected first kind=%0d, model gives %0d", $time, r.data,
                 r.kind_typed, got);
        typed_bad++;
      end
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b0;
    feed_done = 1'b1;
  end

  // Receiver, with one long hold-off once the block is busy
  initial begin
    bit held;
    held = 1'b0;
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!held && sent >= 150) begin
        held = 1'b1;
        m_axis_tready_i <= 1'b0;
        repeat (400) @(negedge clk_i);
      end
      if ($urandom_range(0, 3) == 0) m_axis_tready_i <= 1'b0;
      else if ($urandom_range(0, 40) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(8, 40)) @(negedge clk_i);
      end else m_axis_tready_i <= 1'b1;
    end
  end

  // Result check against the oldest decoded result
  always @(posedge clk_i) begin
    decoded_t e;
    logic [OutDataW-1:0] want;
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        sent <= sent + 1;
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected word kind=%0d data=%h", $time, m_axis_tuser_o,
                   m_axis_tdata_o);
          errors <= errors + 1;
        end else begin
          e = decoded_q.pop_front();
          want = {5'd0, e.error_code, e.block_symbols, e.rle_used, e.final_block,
                  e.block_done, e.symbol};
          if (m_axis_tuser_o != e.kind || m_axis_tdata_o != want
              || m_axis_tlast_o != e.last) begin
            $display("%0t: mismatch expected kind=%0d data=%h last=%b,",
                     $time, e.kind, want, e.last);
            $display("    got kind=%0d data=%h last=%b", m_axis_tuser_o, m_axis_tdata_o,
                     m_axis_tlast_o);
            errors <= errors + 1;
          end
          case (e.kind)
            KIND_HEADER: headers_seen <= headers_seen + 1;
            KIND_SYMBOL: symbols_seen <= symbols_seen + 1;
            default:     errors_seen <= errors_seen + 1;
          endcase
        end
      end
    end
  end

  initial begin
    errors = 0;
    typed_bad = 0;
    sent = 0;
    headers_seen = 0;
    symbols_seen = 0;
    errors_seen = 0;
    idle_cycles = 0;
  end

  // Watchdog on cycles with no accepted word
  initial begin
    wait (idle_cycles >= IdleLimit);
    $display("%0t: no progress for %0d cycles", $time, IdleLimit);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    wait (feed_done && decoded_q.size() == 0);
    repeat (60) @(posedge clk_i);
    if (decoded_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, decoded_q.size());
      errors = errors + 1;
    end
    $display("Sent %0d bytes; checked %0d headers, %0d symbols, %0d error words.",
             sent, headers_seen, symbols_seen, errors_seen);
    if (errors == 0 && typed_bad == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== huffman_block_decoder.f =====
hdl/hbd_pkg.sv
hdl/hbd_ram.sv
hdl/huffman_block_decoder.sv
tb/huffman_block_decoder_tb.sv
